// ===== design/bcb_pkg.sv =====
package bcb_pkg;

    // Q1.16 one and the widths of the fixed-point path
    localparam int T_W      = 18;
    localparam int TU_W     = 17;
    localparam int SQ_W     = 2 * TU_W;
    localparam int CUBE_W   = 49;
    localparam int WGT_W    = 31;
    localparam int COORD_W  = 32;
    localparam int PROD_W   = 63;
    localparam int PAIR_W   = 64;
    localparam int SUM_W    = 65;
    localparam int NUM_PTS  = 4;
    localparam int NUM_REGS = 8;
    localparam int CFG_IDX_W = 3;

    localparam int WGT_SHIFT = 18;
    localparam int SUM_SHIFT = 30;

    // register stages from input transaction to output register
    localparam int PIPE_DEPTH = 7;

    localparam logic [TU_W-1:0] ONE_Q16 = 17'h1_0000;

    typedef enum logic [1:0] {
        SEL_CURVE,
        SEL_P0,
        SEL_P3
    } sel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P0_X,
        REG_P0_Y,
        REG_P1_X,
        REG_P1_Y,
        REG_P2_X,
        REG_P2_Y,
        REG_P3_X,
        REG_P3_Y
    } cfg_reg_t;

    typedef logic [NUM_REGS-1:0][COORD_W-1:0] ctrl_pts_t;

    typedef struct packed {
        logic                          valid;
        sel_t                          sel;
        logic [NUM_PTS-1:0][WGT_W-1:0] wgt;
    } wgt_bus_t;

endpackage

// ===== design/bcb_weights.sv =====
// Bernstein weight pipeline: t -> four Q1.30 weights in four stages.
module bcb_weights import bcb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [T_W-1:0] s_t_param,
    output wgt_bus_t              wgt_out,
    input  logic                  wgt_ready
);

    localparam logic [CUBE_W+1:0] RND_W = (CUBE_W+2)'(1) << (WGT_SHIFT - 1);

    // stage 1: classify, form u = 1 - t
    logic            v1_reg;
    sel_t            sel1_reg, sel1_next;
    logic [TU_W-1:0] t1_reg, u1_reg;
    // stage 2: squares
    logic            v2_reg;
    sel_t            sel2_reg;
    logic [TU_W-1:0] t2_reg, u2_reg;
    logic [SQ_W-1:0] tt2_reg, uu2_reg, ut2_reg;
    // stage 3: cubes
    logic              v3_reg;
    sel_t              sel3_reg;
    logic [CUBE_W-1:0] c0_reg, c1_reg, c2_reg, c3_reg;
    // stage 4: rounded weights
    logic                          v4_reg;
    sel_t                          sel4_reg;
    logic [NUM_PTS-1:0][WGT_W-1:0] w4_reg, w4_next;

    logic en1, en2, en3, en4;
    logic [2*SQ_W-1:0] c0_full, c1_full, c2_full, c3_full;
    logic [CUBE_W+1:0] r0, r1, r2, r3;

    assign en4     = !v4_reg || wgt_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_comb begin
        if (s_t_param[T_W-1]) begin
            sel1_next = SEL_P0;
        end else if (s_t_param[TU_W-1:0] > ONE_Q16) begin
            sel1_next = SEL_P3;
        end else begin
            sel1_next = SEL_CURVE;
        end
    end

    assign c0_full = SQ_W'(uu2_reg) * SQ_W'(u2_reg);
    assign c1_full = SQ_W'(uu2_reg) * SQ_W'(t2_reg);
    assign c2_full = SQ_W'(ut2_reg) * SQ_W'(t2_reg);
    assign c3_full = SQ_W'(tt2_reg) * SQ_W'(t2_reg);

    // weights 1 and 2 carry the factor 3
    always_comb begin
        r0 = (CUBE_W+2)'(c0_reg) + RND_W;
        r1 = (CUBE_W+2)'(c1_reg) + ((CUBE_W+2)'(c1_reg) << 1) + RND_W;
        r2 = (CUBE_W+2)'(c2_reg) + ((CUBE_W+2)'(c2_reg) << 1) + RND_W;
        r3 = (CUBE_W+2)'(c3_reg) + RND_W;
        w4_next[0] = r0[WGT_SHIFT +: WGT_W];
        w4_next[1] = r1[WGT_SHIFT +: WGT_W];
        w4_next[2] = r2[WGT_SHIFT +: WGT_W];
        w4_next[3] = r3[WGT_SHIFT +: WGT_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            sel1_reg <= sel1_next;
            t1_reg   <= s_t_param[TU_W-1:0];
            u1_reg   <= ONE_Q16 - s_t_param[TU_W-1:0];
        end
        if (en2) begin
            sel2_reg <= sel1_reg;
            t2_reg   <= t1_reg;
            u2_reg   <= u1_reg;
            tt2_reg  <= SQ_W'(t1_reg) * SQ_W'(t1_reg);
            uu2_reg  <= SQ_W'(u1_reg) * SQ_W'(u1_reg);
            ut2_reg  <= SQ_W'(u1_reg) * SQ_W'(t1_reg);
        end
        if (en3) begin
            sel3_reg <= sel2_reg;
            c0_reg   <= c0_full[CUBE_W-1:0];
            c1_reg   <= c1_full[CUBE_W-1:0];
            c2_reg   <= c2_full[CUBE_W-1:0];
            c3_reg   <= c3_full[CUBE_W-1:0];
        end
        if (en4) begin
            sel4_reg <= sel3_reg;
            w4_reg   <= w4_next;
        end
    end

    assign wgt_out.valid = v4_reg;
    assign wgt_out.sel   = sel4_reg;
    assign wgt_out.wgt   = w4_reg;

endmodule

// ===== design/bcb_blend.sv =====
// Weighted sum of control points: products, adder tree, round and saturate, or end-point bypass.
module bcb_blend import bcb_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  wgt_bus_t                  wgt_in,
    output logic                      wgt_ready,
    input  ctrl_pts_t                 ctrl_pts,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_point_x,
    output logic signed [COORD_W-1:0] m_point_y
);

    localparam logic signed [SUM_W-1:0] RND_S = SUM_W'(1) << (SUM_SHIFT - 1);
    localparam int SH_W = SUM_W - SUM_SHIFT;

    logic                            v5_reg, v6_reg, v7_reg;
    sel_t                            sel5_reg, sel6_reg;
    logic [NUM_REGS-1:0][PROD_W-1:0] prod5_reg, prod5_next;
    // pair sums: [0] x01, [1] x23, [2] y01, [3] y23
    logic [3:0][PAIR_W-1:0]          pair6_reg, pair6_next;
    logic signed [COORD_W-1:0]       px_reg, py_reg, px_next, py_next;

    logic en5, en6, en7;

    assign en7       = !v7_reg || m_ready;
    assign en6       = !v6_reg || en7;
    assign en5       = !v5_reg || en6;
    assign wgt_ready = en5;

    always_comb begin
        logic signed [2*COORD_W-1:0] p;
        for (int i = 0; i < NUM_REGS; i++) begin
            p = $signed(ctrl_pts[i]) * $signed({1'b0, wgt_in.wgt[i/2]});
            prod5_next[i] = p[PROD_W-1:0];
        end
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int h = 0; h < 2; h++) begin
                pair6_next[2*a+h] = PAIR_W'($signed(prod5_reg[4*h+a]))
                                  + PAIR_W'($signed(prod5_reg[4*h+a+2]));
            end
        end
    end

    function automatic logic [COORD_W-1:0] round_sat(input logic [PAIR_W-1:0] s01,
                                                     input logic [PAIR_W-1:0] s23);
        logic signed [SUM_W-1:0] tot;
        logic signed [SH_W-1:0]  sh;
        logic [COORD_W-1:0]      res;
        tot = SUM_W'($signed(s01)) + SUM_W'($signed(s23)) + RND_S;
        sh  = tot[SUM_W-1:SUM_SHIFT];
        if (sh[SH_W-1:COORD_W-1] == '0 || sh[SH_W-1:COORD_W-1] == '1) begin
            res = sh[COORD_W-1:0];
        end else if (sh[SH_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // end-point bypass; the user must change the registers only while idle, the block does not enforce it
    always_comb begin
        unique case (sel6_reg)
            SEL_P0: begin
                px_next = $signed(ctrl_pts[REG_P0_X]);
                py_next = $signed(ctrl_pts[REG_P0_Y]);
            end
            SEL_P3: begin
                px_next = $signed(ctrl_pts[REG_P3_X]);
                py_next = $signed(ctrl_pts[REG_P3_Y]);
            end
            default: begin
                px_next = $signed(round_sat(pair6_reg[0], pair6_reg[1]));
                py_next = $signed(round_sat(pair6_reg[2], pair6_reg[3]));
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (en5) v5_reg <= wgt_in.valid;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            sel5_reg  <= wgt_in.sel;
            prod5_reg <= prod5_next;
        end
        if (en6) begin
            sel6_reg  <= sel5_reg;
            pair6_reg <= pair6_next;
        end
        if (en7) begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    assign m_valid   = v7_reg;
    assign m_point_x = px_reg;
    assign m_point_y = py_reg;

endmodule

// ===== design/cubic_bezier_point_eval_core.sv =====
// Cubic Bezier point evaluator. Write the four control points (signed
// Q15.16) through the cfg port while no transaction is in flight, then
// stream curve parameters t (signed Q1.16, 65536 = 1.0). Each input
// transaction yields exactly one output point, in order. t below zero
// returns p0 and t above one returns p3 unchanged; otherwise the point is
// the Bernstein-weighted sum, rounded to nearest (half up) and saturated to
// 32 bits. Throughput is one transaction per cycle while m_ready is high.
// Register chain from input acceptance to output valid: u/t capture,
// squares, cubes, weight rounding, 32x31 point products, pair adds, and a
// final add with round and saturate. Every stage holds under backpressure
// and bubbles close up, so the input stays ready while any stage is empty.
module cubic_bezier_point_eval_core import bcb_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration writes
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [COORD_W-1:0]          cfg_wdata,
    // parameter transactions
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [T_W-1:0]       s_t_param,
    // point transactions
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [COORD_W-1:0]   m_point_x,
    output logic signed [COORD_W-1:0]   m_point_y
);

    // control point registers, laid out as p0_x, p0_y, ... p3_y
    ctrl_pts_t ctrl_pts_reg;
    wgt_bus_t  wgt_bus;
    logic      wgt_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_pts_reg <= '0;
        end else if (cfg_wr_en) begin
            ctrl_pts_reg[cfg_index] <= cfg_wdata;
        end
    end

    // stages 1-4: weights from t
    bcb_weights u_weights (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_t_param (s_t_param),
        .wgt_out   (wgt_bus),
        .wgt_ready (wgt_ready)
    );

    // stages 5-7: blend control points and finish
    bcb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wgt_in    (wgt_bus),
        .wgt_ready (wgt_ready),
        .ctrl_pts  (ctrl_pts_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_point_x (m_point_x),
        .m_point_y (m_point_y)
    );

endmodule

// ===== design/bcb_checker.sv =====
// Port-level checks: output hold, reset, and occupancy bookkeeping.
module bcb_checker import bcb_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [COORD_W-1:0] m_point_x,
    input logic signed [COORD_W-1:0] m_point_y
);

    // transactions accepted but not yet delivered
    logic [3:0] occ_reg, occ_next;

    always_comb begin
        occ_next = occ_reg;
        if (s_valid && s_ready) occ_next = occ_next + 4'd1;
        if (m_valid && m_ready) occ_next = occ_next - 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_x) && $stable(m_point_y))
        else $error("output changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> occ_reg != 4'd0)
        else $error("output transaction with nothing in flight");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= 4'(PIPE_DEPTH))
        else $error("more transactions in flight than stages");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg < 4'(PIPE_DEPTH) |-> s_ready)
        else $error("input stalled with an empty stage");

endmodule

bind cubic_bezier_point_eval_core bcb_checker u_bcb_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_point_x (m_point_x),
    .m_point_y (m_point_y)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bcb_pkg::*;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

    // control point sets used per phase
    typedef enum int {
        PTS_RESET,
        PTS_RANDOM,
        PTS_ALL_MAX,
        PTS_ALL_MIN,
        PTS_X_MAX_Y_MIN,
        PTS_ENDS_VS_CTRL,
        PTS_NEAR_ZERO
    } pts_kind_t;

    localparam int NUM_PHASES = 10;
    localparam int RAND_PER_PHASE = 40;
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // configuration port
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_wdata = '0;

    // parameter channel
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic signed [T_W-1:0] s_t_param = '0;

    // point channel
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [COORD_W-1:0] m_point_x;
    logic signed [COORD_W-1:0] m_point_y;

    // testbench copy of the control point registers
    logic signed [COORD_W-1:0] ctrl_pts [NUM_REGS];

    // parameters waiting to be sent, points waiting to come back
    logic signed [T_W-1:0] t_backlog [$];
    point_t                expected_points [$];

    int send_idle_max = 12;
    int recv_idle_max = 12;
    int send_gap = 0;
    int recv_stall = 0;
    int mismatch_cnt = 0;

    always #1 aclk = ~aclk;

    cubic_bezier_point_eval_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_t_param (s_t_param),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_point_x (m_point_x),
        .m_point_y (m_point_y)
    );

    // Round the Q.46 weighted sum to Q15.16, half toward +inf, then clamp
    // to the signed 32-bit range.
    function automatic logic [COORD_W-1:0] round_sat(longint acc);
        longint r;
        r = (acc + (longint'(1) <<< (SUM_SHIFT - 1))) >>> SUM_SHIFT;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[COORD_W-1:0];
    endfunction

    // Expected curve point for one parameter under the current registers.
    function automatic point_t curve_point(logic signed [T_W-1:0] t);
        point_t p;
        longint unsigned tu;
        longint unsigned uu;
        longint unsigned half_lsb;
        longint w [NUM_PTS];
        longint sx;
        longint sy;
        // below zero: start point as is
        if (t < 0) begin
            p.x = ctrl_pts[REG_P0_X];
            p.y = ctrl_pts[REG_P0_Y];
            return p;
        end
        // beyond one: end point as is
        if (t > $signed({1'b0, ONE_Q16})) begin
            p.x = ctrl_pts[REG_P3_X];
            p.y = ctrl_pts[REG_P3_Y];
            return p;
        end
        tu = t;
        uu = longint'(ONE_Q16) - tu;
        half_lsb = longint'(1) << (WGT_SHIFT - 1);
        // Bernstein weights exact at 48 fraction bits, rounded to Q1.30
        w[0] = (uu * uu * uu + half_lsb) >> WGT_SHIFT;
        w[1] = (64'd3 * uu * uu * tu + half_lsb) >> WGT_SHIFT;
        w[2] = (64'd3 * uu * tu * tu + half_lsb) >> WGT_SHIFT;
        w[3] = (tu * tu * tu + half_lsb) >> WGT_SHIFT;
        sx = longint'(ctrl_pts[REG_P0_X]) * w[0] + longint'(ctrl_pts[REG_P1_X]) * w[1]
           + longint'(ctrl_pts[REG_P2_X]) * w[2] + longint'(ctrl_pts[REG_P3_X]) * w[3];
        sy = longint'(ctrl_pts[REG_P0_Y]) * w[0] + longint'(ctrl_pts[REG_P1_Y]) * w[1]
           + longint'(ctrl_pts[REG_P2_Y]) * w[2] + longint'(ctrl_pts[REG_P3_Y]) * w[3];
        p.x = round_sat(sx);
        p.y = round_sat(sy);
        return p;
    endfunction

    // Random parameter: mostly inside [0,1], with clamped regions, exact
    // end values and raw 18-bit patterns mixed in.
    function automatic logic signed [T_W-1:0] random_t();
        logic signed [T_W-1:0] t;
        case ($urandom_range(0, 9))
            6: begin
                case ($urandom_range(0, 3))
                    0: t = 0;
                    1: t = 1;
                    2: t = ONE_Q16 - 1;
                    default: t = ONE_Q16;
                endcase
            end
            7: t = -$signed($urandom_range(1, 131072));
            8: t = $urandom_range(65537, 131071);
            9: t = $urandom;
            default: t = $urandom_range(0, 65536);
        endcase
        return t;
    endfunction

    // Parameter driver: pops the backlog, holds valid and payload steady
    // until the transaction goes through, then idles a random number of
    // cycles before offering the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready)
                expected_points.push_back(curve_point(s_t_param));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (t_backlog.size() > 0) begin
                    s_t_param <= t_backlog.pop_front();
                    s_valid   <= 1'b1;
                    send_gap = $urandom_range(0, send_idle_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Point monitor: checks each transaction against the oldest expectation
    // and stalls ready for a random number of cycles after each one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected point transaction x=%h y=%h", m_point_x, m_point_y);
                    mismatch_cnt++;
                end else begin
                    point_t exp_pt;
                    exp_pt = expected_points.pop_front();
                    if (m_point_x !== exp_pt.x) begin
                        $error("point_x: expected %h, actual %h", exp_pt.x, m_point_x);
                        mismatch_cnt++;
                    end
                    if (m_point_y !== exp_pt.y) begin
                        $error("point_y: expected %h, actual %h", exp_pt.y, m_point_y);
                        mismatch_cnt++;
                    end
                end
                recv_stall = $urandom_range(0, recv_idle_max);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            m_ready <= (recv_stall == 0);
        end
    end

    // One register write per clock; the model copy follows at once since
    // nothing is in flight while the registers change.
    task automatic write_reg(cfg_reg_t idx, logic [COORD_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        ctrl_pts[idx] = val;
    endtask

    task automatic load_points(pts_kind_t kind);
        logic [COORD_W-1:0] val;
        for (int i = 0; i < NUM_REGS; i++) begin
            case (kind)
                PTS_ALL_MAX:      val = 32'h7FFF_FFFF;
                PTS_ALL_MIN:      val = 32'h8000_0000;
                // x registers at the top, y registers at the bottom
                PTS_X_MAX_Y_MIN:  val = (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                // end points against control points of opposite sign
                PTS_ENDS_VS_CTRL: begin
                    if (cfg_reg_t'(i) inside {REG_P0_X, REG_P0_Y, REG_P3_X, REG_P3_Y})
                        val = 32'h7FFF_FFFF;
                    else
                        val = 32'h8000_0000;
                end
                PTS_NEAR_ZERO:    val = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
                default:          val = $urandom;
            endcase
            write_reg(cfg_reg_t'(i), val);
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sender holds off until every point is back and the pipe is empty.
    task automatic drain();
        do
            @(negedge aclk);
        while (t_backlog.size() != 0 || s_valid || expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Stimulus: phases of parameter streams, each under its own control
    // point set, reprogrammed only while the block is empty.
    initial begin
        logic signed [T_W-1:0] edge_ts [5];
        logic signed [T_W-1:0] sweep_ts [17];
        pts_kind_t kind;

        edge_ts  = '{0, ONE_Q16, 32768, -1, 131071};
        sweep_ts = '{-131072, -65536, -1, 0, 1, 2, 16384, 21845, 32768, 43690,
                     65534, 65535, 65536, 65537, 98304, 131071, 18'h15555};

        for (int r = 0; r < NUM_REGS; r++)
            ctrl_pts[r] = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0)
                kind = PTS_RESET;
            else if (ph == 1)
                kind = PTS_RANDOM;
            else
                kind = pts_kind_t'(1 + (ph - 2) % 6);
            if (kind != PTS_RESET)
                load_points(kind);

            // every third phase runs both sides without idling
            @(negedge aclk);
            send_idle_max = (ph % 3 == 2) ? 0 : 12;
            recv_idle_max = (ph % 3 == 2) ? 0 : 12;

            // directed: full sweep once, end and midpoint values every phase
            if (ph == 1) begin
                foreach (sweep_ts[i])
                    t_backlog.push_back(sweep_ts[i]);
            end else begin
                foreach (edge_ts[i])
                    t_backlog.push_back(edge_ts[i]);
            end
            for (int i = 0; i < RAND_PER_PHASE; i++)
                t_backlog.push_back(random_t());

            drain();
        end

        if (mismatch_cnt == 0)
            $display("cubic_bezier_point_eval_core test passed");
        else
            $display("cubic_bezier_point_eval_core test failed");
        $finish;
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("cubic_bezier_point_eval_core test failed");
        $finish;
    end

endmodule

// ===== cubic_bezier_point_eval_core.f =====
design/bcb_pkg.sv
design/bcb_weights.sv
design/bcb_blend.sv
design/cubic_bezier_point_eval_core.sv
design/bcb_checker.sv
dv/testbench.sv
